>>> src/kvt_pkg.sv
// Package for the clustered key-value table: sizes, command and status codes,
// and the structs passed between the sequencer, the scan unit and the store.
// No dependencies.
`default_nettype none

package kvt_pkg;

  localparam int unsigned SLOTS_PER_CLUSTER = 16;
  localparam int unsigned NUM_CLUSTERS      = 64;
  localparam int unsigned TOTAL_SLOTS       = SLOTS_PER_CLUSTER * NUM_CLUSTERS;

  localparam int unsigned POS_W  = $clog2(SLOTS_PER_CLUSTER);
  localparam int unsigned CL_W   = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int unsigned SLOT_W = POS_W + CL_W;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OFS_W  = 31;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Store access: a read and a write port each for slots and valid rows.
  typedef struct packed {
    logic [SLOT_W-1:0]            rd_slot;
    logic [CL_W-1:0]              rd_row;
    logic                         slot_we;
    logic [SLOT_W-1:0]            wr_slot;
    logic [KEY_W-1:0]             wr_key;
    logic [VAL_W-1:0]             wr_val;
    logic                         row_we;
    logic [CL_W-1:0]              wr_row;
    logic [SLOTS_PER_CLUSTER-1:0] row_wdata;
  } store_req_t;

  typedef struct packed {
    logic init;
    logic step;
    logic match_en;
  } scan_ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] rd_pos;
    logic             last;
    logic             match_now;
    logic             hit;
    logic [POS_W-1:0] hit_pos;
    logic [VAL_W-1:0] hit_val;
    logic             free;
    logic [POS_W-1:0] free_pos;
  } scan_res_t;

endpackage

`default_nettype wire

>>> src/clustered_key_value_table_top.sv
// Top level of the clustered key-value table: command sequencer, key offset
// register and result register. Uses kvt_pkg, kvt_store and kvt_scan.
`default_nettype none

// The table holds 64 clusters of 16 slots. A command's key picks cluster
// (key + key_offset) / 16; the command then scans that cluster's slots from
// the lowest upward, one slot per cycle through a single key comparator,
// stopping at the first valid slot with a matching key (insert does not
// compare keys and scans all 16). Insert takes the lowest free slot, lookup
// returns the matching value, remove clears the slot's valid bit, update
// rewrites the value or inserts when the key is absent. One item is worked
// on at a time: the input stalls from acceptance until its result has been
// loaded into the output register. An item passes the load, scan and act
// states, scanning up to 16 slots, and waits in act while the output
// register is full; a key out of range goes straight to act. The scan
// through the key memory read port paces an item. The output register lets
// a new item be accepted while the last result still waits. After reset the
// block runs a clearing pass over the valid memory (one cluster row a
// cycle) and stalls its input meanwhile. The key_offset register may be
// written at any time but should only change while the block is idle.
module clustered_key_value_table_top import kvt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [OFS_W-1:0]        cfg_data_i,
  // command items
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic signed [VAL_W-1:0] value_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STAT_W-1:0]       status_o,
  output logic signed [VAL_W-1:0] found_value_o,
  output logic [IDX_W-1:0]        slot_index_o
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_ACT
  } state_e;

  state_e state_q, state_d;

  logic [OFS_W-1:0] key_offset_q;
  logic [CL_W-1:0]  clr_row_q;

  cmd_e             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [CL_W-1:0]  cluster_q;
  logic             range_ok_q;

  logic             out_valid_q;
  status_e          status_q;
  logic [VAL_W-1:0] fval_q;
  logic [IDX_W-1:0] slot_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         act_go;
  logic signed [KEY_W:0]        biased;
  logic                         range_ok;
  store_req_t                   store_req;
  scan_ctrl_t                   scan_ctrl;
  scan_res_t                    scan_res;
  logic [KEY_W-1:0]             key_rd;
  logic [VAL_W-1:0]             val_rd;
  logic [SLOTS_PER_CLUSTER-1:0] row_rd;

  // Outcome of the scan, applied in the act state.
  status_e                      dec_status;
  logic [VAL_W-1:0]             dec_fval;
  logic [POS_W-1:0]             dec_pos;
  logic                         dec_slot_we;
  logic                         dec_row_we;
  logic [SLOTS_PER_CLUSTER-1:0] dec_row;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign act_go      = (state_q == S_ACT) && out_free;

  // Bias the signed key; both operands fit in one more bit.
  assign biased   = $signed({key_i[KEY_W-1], key_i}) + $signed({2'b00, key_offset_q});
  assign range_ok = !biased[KEY_W] && (biased[KEY_W-1:0] < KEY_W'(TOTAL_SLOTS));

  kvt_store u_store (
    .clk_i    (clk_i),
    .req_i    (store_req),
    .key_rd_o (key_rd),
    .val_rd_o (val_rd),
    .row_rd_o (row_rd)
  );

  kvt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (scan_ctrl),
    .key_i    (key_q),
    .key_rd_i (key_rd),
    .val_rd_i (val_rd),
    .row_rd_i (row_rd),
    .res_o    (scan_res)
  );

  // Decide the command's outcome from the scan flags and the cluster row.
  always_comb begin
    dec_status  = ST_RANGE;
    dec_fval    = '0;
    dec_pos     = '0;
    dec_slot_we = 1'b0;
    dec_row_we  = 1'b0;
    dec_row     = row_rd;
    if (range_ok_q) begin
      if (cmd_q == CMD_LOOKUP || cmd_q == CMD_REMOVE) begin
        if (scan_res.hit) begin
          dec_status = ST_OK;
          dec_pos    = scan_res.hit_pos;
          if (cmd_q == CMD_LOOKUP) begin
            dec_fval = scan_res.hit_val;
          end else begin
            dec_row_we                    = 1'b1;
            dec_row[scan_res.hit_pos]     = 1'b0;
          end
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end else if (scan_res.hit) begin
        // rewrite value in place; the stored key is already equal
        dec_status  = ST_OK;
        dec_pos     = scan_res.hit_pos;
        dec_fval    = val_q;
        dec_slot_we = 1'b1;
      end else if (scan_res.free) begin
        dec_status                 = ST_OK;
        dec_pos                    = scan_res.free_pos;
        dec_fval                   = (cmd_q == CMD_UPDATE) ? val_q : '0;
        dec_slot_we                = 1'b1;
        dec_row_we                 = 1'b1;
        dec_row[scan_res.free_pos] = 1'b1;
      end else begin
        dec_status = ST_FULL;
      end
    end
  end

  always_comb begin
    state_d            = state_q;
    scan_ctrl          = '0;
    scan_ctrl.match_en = (cmd_q != CMD_INSERT);
    store_req          = '0;
    store_req.rd_row   = cluster_q;
    store_req.rd_slot  = {cluster_q, scan_res.rd_pos};
    store_req.wr_slot  = {cluster_q, dec_pos};
    store_req.wr_key   = key_q;
    store_req.wr_val   = val_q;
    store_req.wr_row   = cluster_q;
    store_req.row_wdata = dec_row;
    case (state_q)
      S_CLR: begin
        store_req.row_we    = 1'b1;
        store_req.wr_row    = clr_row_q;
        store_req.row_wdata = '0;
        if (clr_row_q == CL_W'(NUM_CLUSTERS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = range_ok ? S_LOAD : S_ACT;
        end
      end
      S_LOAD: begin
        // issue reads of the cluster row and slot zero
        scan_ctrl.init = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (scan_res.match_now || scan_res.last) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        // hold until the result register can take the result
        if (out_free) begin
          store_req.slot_we = dec_slot_we;
          store_req.row_we  = dec_row_we;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_row_q    <= '0;
      key_offset_q <= '0;
      range_ok_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_row_q <= clr_row_q + CL_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        key_offset_q <= cfg_data_i;
      end
      if (in_accept) begin
        range_ok_q <= range_ok;
      end
      if (act_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q     <= cmd_e'(command_i);
      key_q     <= key_i;
      val_q     <= value_i;
      cluster_q <= biased[POS_W +: CL_W];
    end
    if (act_go) begin
      status_q <= dec_status;
      fval_q   <= dec_fval;
      slot_q   <= (dec_status == ST_OK) ? IDX_W'({cluster_q, dec_pos}) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = fval_q;
  assign slot_index_o  = slot_q;

`ifndef SYNTHESIS
  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (slot_index_o == '0 && found_value_o == '0))
    else $error("failed command carries a slot or value");

  a_act_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACT && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("result not loaded on leaving act");

  a_range_skips_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !range_ok) |=> (state_q == S_ACT))
    else $error("out-of-range key started a scan");
`endif

endmodule

`default_nettype wire

>>> src/kvt_store.sv
// Slot storage: key and value memories (one entry per slot) and the valid
// memory (one row per cluster). Registered reads. Uses kvt_pkg.
`default_nettype none

module kvt_store import kvt_pkg::*; (
  input  logic                         clk_i,
  input  store_req_t                   req_i,
  output logic [KEY_W-1:0]             key_rd_o,
  output logic [VAL_W-1:0]             val_rd_o,
  output logic [SLOTS_PER_CLUSTER-1:0] row_rd_o
);

  logic [KEY_W-1:0]             key_mem_q [TOTAL_SLOTS];
  logic [VAL_W-1:0]             val_mem_q [TOTAL_SLOTS];
  logic [SLOTS_PER_CLUSTER-1:0] row_mem_q [NUM_CLUSTERS];

  logic [KEY_W-1:0]             key_rd_q;
  logic [VAL_W-1:0]             val_rd_q;
  logic [SLOTS_PER_CLUSTER-1:0] row_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.slot_we) begin
      key_mem_q[req_i.wr_slot] <= req_i.wr_key;
      val_mem_q[req_i.wr_slot] <= req_i.wr_val;
    end
    key_rd_q <= key_mem_q[req_i.rd_slot];
    val_rd_q <= val_mem_q[req_i.rd_slot];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.row_we) begin
      row_mem_q[req_i.wr_row] <= req_i.row_wdata;
    end
    row_rd_q <= row_mem_q[req_i.rd_row];
  end

  assign key_rd_o = key_rd_q;
  assign val_rd_o = val_rd_q;
  assign row_rd_o = row_rd_q;

endmodule

`default_nettype wire

>>> src/kvt_scan.sv
// Scan unit: one key compare per step cycle over a cluster's slots, tracking
// the first matching slot and the lowest free slot. Uses kvt_pkg.
`default_nettype none

module kvt_scan import kvt_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  scan_ctrl_t                   ctrl_i,
  input  logic [KEY_W-1:0]             key_i,
  input  logic [KEY_W-1:0]             key_rd_i,
  input  logic [VAL_W-1:0]             val_rd_i,
  input  logic [SLOTS_PER_CLUSTER-1:0] row_rd_i,
  output scan_res_t                    res_o
);

  logic [POS_W-1:0] pos_q;
  logic             hit_q;
  logic [POS_W-1:0] hit_pos_q;
  logic [VAL_W-1:0] hit_val_q;
  logic             free_q;
  logic [POS_W-1:0] free_pos_q;

  logic bit_now;
  logic match_now;
  logic free_now;

  assign bit_now   = row_rd_i[pos_q];
  assign match_now = ctrl_i.step && ctrl_i.match_en && bit_now && (key_rd_i == key_i);
  assign free_now  = ctrl_i.step && !bit_now && !free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (ctrl_i.init) begin
      pos_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (ctrl_i.step) begin
      pos_q <= pos_q + POS_W'(1);
      if (match_now) begin
        hit_q <= 1'b1;
      end
      if (free_now) begin
        free_q <= 1'b1;
      end
    end
  end

  // Capture position and value of the first match and of the first hole.
  always_ff @(posedge clk_i) begin
    if (match_now) begin
      hit_pos_q <= pos_q;
      hit_val_q <= val_rd_i;
    end
    if (free_now) begin
      free_pos_q <= pos_q;
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.rd_pos    = ctrl_i.init ? '0 : pos_q + POS_W'(1);
    res_o.last      = (pos_q == POS_W'(SLOTS_PER_CLUSTER - 1));
    res_o.match_now = match_now;
    res_o.hit       = hit_q;
    res_o.hit_pos   = hit_pos_q;
    res_o.hit_val   = hit_val_q;
    res_o.free      = free_q;
    res_o.free_pos  = free_pos_q;
  end

`ifndef SYNTHESIS
  // The sequencer stops stepping at the first match.
  a_no_step_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |-> !hit_q) else $error("scan stepped past a match");

  a_free_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q && !ctrl_i.init) |=> (free_q && $stable(free_pos_q)))
    else $error("lowest free slot moved during scan");

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.init |=> (!hit_q && !free_q && pos_q == '0))
    else $error("scan start did not clear tracking state");
`endif

endmodule

`default_nettype wire
